>>> sv/rectangle_min_distance_defines.svh
// Assertion macros used by the checker file of the rectangle distance block.
`ifndef RECTANGLE_MIN_DISTANCE_DEFINES_SVH
`define RECTANGLE_MIN_DISTANCE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RMD_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmd check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RMD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmd check failed");

`endif

>>> sv/rmd_pkg.sv
// Shared constants and types of the rectangle distance block.
`default_nettype none
package rmd_pkg;

  // Default coordinate width (signed Q16.8).
  localparam int unsigned COORD_BITS_DEF = 24;
  // Width of the distance result (unsigned Q17.8).
  localparam int unsigned DIST_W = 25;

  // Control that travels alongside each word in the pipeline.
  typedef struct packed {
    logic valid;
    logic overlap;
  } rmd_ctl_t;

endpackage
`default_nettype wire

>>> sv/rmd_in_if.sv
// Input channel: one pair of rectangles per word.
`default_nettype none
interface rmd_in_if import rmd_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_left;
  logic signed [COORD_BITS-1:0] a_bottom;
  logic signed [COORD_BITS-1:0] a_right;
  logic signed [COORD_BITS-1:0] a_top;
  logic signed [COORD_BITS-1:0] b_left;
  logic signed [COORD_BITS-1:0] b_bottom;
  logic signed [COORD_BITS-1:0] b_right;
  logic signed [COORD_BITS-1:0] b_top;

  modport source (
    output valid, a_left, a_bottom, a_right, a_top, b_left, b_bottom, b_right, b_top,
    input  ready
  );
  modport sink (
    input  valid, a_left, a_bottom, a_right, a_top, b_left, b_bottom, b_right, b_top,
    output ready
  );
endinterface
`default_nettype wire

>>> sv/rmd_out_if.sv
// Output channel: one distance result per word.
`default_nettype none
interface rmd_out_if import rmd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] gap_distance;
  logic              overlap;

  modport source (output valid, gap_distance, overlap, input ready);
  modport sink (input valid, gap_distance, overlap, output ready);
endinterface
`default_nettype wire

>>> sv/rmd_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
`default_nettype none
module rmd_sqrt import rmd_pkg::*; #(
  parameter int unsigned ROOT_W = COORD_BITS_DEF + 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [2*ROOT_W-1:0]   rad_i,
  input  wire rmd_ctl_t              ctl_i,
  output logic                       ready_o,
  output logic      [ROOT_W-1:0]     root_o,
  output rmd_ctl_t                   ctl_o,
  input  wire logic                  ready_i
);

  localparam int unsigned RadW = 2 * ROOT_W;
  localparam int unsigned RemW = ROOT_W + 2;

  logic [RadW-1:0]   rad_q  [ROOT_W];
  logic [RemW-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  rmd_ctl_t          ctl_q  [ROOT_W];
  logic              rdy    [ROOT_W+1];

  assign rdy[ROOT_W] = ready_i;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [RadW-1:0]   p_rad;
    logic [RemW-1:0]   p_rem;
    logic [ROOT_W-1:0] p_root;
    rmd_ctl_t          p_ctl;
    logic [RemW-1:0]   rem_sh;
    logic [RemW-1:0]   trial;
    logic              take;

    if (s == 0) begin : g_first
      assign p_rad  = rad_i;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_ctl  = ctl_i;
    end else begin : g_next
      assign p_rad  = rad_q[s-1];
      assign p_rem  = rem_q[s-1];
      assign p_root = root_q[s-1];
      assign p_ctl  = ctl_q[s-1];
    end

    // Bring down the next two radicand bits and try root bit one.
    assign rem_sh = {p_rem[ROOT_W-1:0], p_rad[RadW-1 -: 2]};
    assign trial  = {p_root, 2'b01};
    assign take   = (rem_sh >= trial);

    assign rdy[s] = !ctl_q[s].valid || rdy[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else if (rdy[s]) begin
        ctl_q[s] <= p_ctl;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && p_ctl.valid) begin
        rad_q[s]  <= {p_rad[RadW-3:0], 2'b00};
        rem_q[s]  <= take ? (rem_sh - trial) : rem_sh;
        root_q[s] <= {p_root[ROOT_W-2:0], take};
      end
    end
  end

  assign ready_o = rdy[0];
  assign root_o  = root_q[ROOT_W-1];
  assign ctl_o   = ctl_q[ROOT_W-1];

endmodule
`default_nettype wire

>>> sv/rectangle_min_distance.sv
// Each accepted word passes the gap, square and sum stages and then the root stages.
// Throughput: one rectangle pair per cycle unless stalled; the three front stages and
//   the one-bit-per-stage square root pipeline each take a new word every cycle.
// Backpressure on the output stalls only the stages that hold data; empty
//   stages keep filling, so the input stays ready while any stage is free.
// Reset (asynchronous, active low) clears every valid bit; data registers are not reset.
`default_nettype none
module rectangle_min_distance import rmd_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rmd_in_if.sink    in_i,
  rmd_out_if.source out_o
);

  // Gaps are unsigned and fit COORD_BITS bits; their squares fit twice that,
  // the sum one bit more, and the root COORD_BITS + 1 bits.
  localparam int unsigned GapW  = COORD_BITS;
  localparam int unsigned DiffW = COORD_BITS + 1;
  localparam int unsigned SqW   = 2 * COORD_BITS;
  localparam int unsigned SumW  = 2 * COORD_BITS + 1;
  localparam int unsigned RootW = COORD_BITS + 1;

  // ------------------------------------------------------------------
  // Stage 1: separation tests and the horizontal and vertical gaps.
  // ------------------------------------------------------------------
  logic signed [DiffW-1:0] al_x, ab_x, ar_x, at_x, bl_x, bb_x, br_x, bt_x;
  logic signed [DiffW-1:0] gap_xl, gap_xr, gap_yb, gap_yt;
  logic                    x_lt, x_gt, y_lt, y_gt, apart;
  logic [GapW-1:0]         dx_d, dy_d, dx_q, dy_q;
  rmd_ctl_t                s1_ctl_d, s1_ctl_q;
  logic                    s1_rdy;

  assign al_x = DiffW'(in_i.a_left);
  assign ab_x = DiffW'(in_i.a_bottom);
  assign ar_x = DiffW'(in_i.a_right);
  assign at_x = DiffW'(in_i.a_top);
  assign bl_x = DiffW'(in_i.b_left);
  assign bb_x = DiffW'(in_i.b_bottom);
  assign br_x = DiffW'(in_i.b_right);
  assign bt_x = DiffW'(in_i.b_top);

  // Touching edges or corners are not apart: all tests are strict.
  assign x_lt  = (ar_x < bl_x);
  assign x_gt  = (al_x > br_x);
  assign y_lt  = (at_x < bb_x);
  assign y_gt  = (ab_x > bt_x);
  assign apart = x_lt || x_gt || y_lt || y_gt;

  assign gap_xl = bl_x - ar_x;
  assign gap_xr = al_x - br_x;
  assign gap_yb = bb_x - at_x;
  assign gap_yt = ab_x - bt_x;

  // With inverted corners both tests on one axis may hold; the second gap
  // then wins. Overlapping pairs carry zero gaps, so the root comes out zero.
  // A zero gap on one axis needs no bypass: the root of the other gap's
  // square is that gap exactly.
  always_comb begin
    dx_d = '0;
    dy_d = '0;
    if (x_lt) begin
      dx_d = gap_xl[GapW-1:0];
    end
    if (x_gt) begin
      dx_d = gap_xr[GapW-1:0];
    end
    if (y_lt) begin
      dy_d = gap_yb[GapW-1:0];
    end
    if (y_gt) begin
      dy_d = gap_yt[GapW-1:0];
    end
  end

  assign s1_ctl_d.valid   = in_i.valid;
  assign s1_ctl_d.overlap = !apart;

  // ------------------------------------------------------------------
  // Stage 2: squares of both gaps.
  // ------------------------------------------------------------------
  logic [SqW-1:0] sqx_d, sqy_d, sqx_q, sqy_q;
  rmd_ctl_t       s2_ctl_q;
  logic           s2_rdy;

  assign sqx_d = SqW'(dx_q) * SqW'(dx_q);
  assign sqy_d = SqW'(dy_q) * SqW'(dy_q);

  // ------------------------------------------------------------------
  // Stage 3: sum of squares, the radicand of the root pipeline.
  // ------------------------------------------------------------------
  logic [SumW-1:0] sum_d, sum_q;
  rmd_ctl_t        s3_ctl_q;
  logic            s3_rdy;

  assign sum_d = SumW'(sqx_q) + SumW'(sqy_q);

  // Each stage loads when it is empty or its successor loads this cycle.
  logic            sqrt_rdy;
  logic [RootW-1:0] root;
  rmd_ctl_t        root_ctl;

  assign s3_rdy = !s3_ctl_q.valid || sqrt_rdy;
  assign s2_rdy = !s2_ctl_q.valid || s3_rdy;
  assign s1_rdy = !s1_ctl_q.valid || s2_rdy;
  assign in_i.ready = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
    end else begin
      if (s1_rdy) begin
        s1_ctl_q <= s1_ctl_d;
      end
      if (s2_rdy) begin
        s2_ctl_q <= s1_ctl_q;
      end
      if (s3_rdy) begin
        s3_ctl_q <= s2_ctl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_i.valid) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (s2_rdy && s1_ctl_q.valid) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
    end
    if (s3_rdy && s2_ctl_q.valid) begin
      sum_q <= sum_d;
    end
  end

  // ------------------------------------------------------------------
  // Square root: one root bit per stage; its last stage is the output
  // register, so a waiting result stalls the stages behind it only once
  // every one of them holds data.
  // ------------------------------------------------------------------
  rmd_sqrt #(
    .ROOT_W (RootW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rad_i   ((2 * RootW)'(sum_q)),
    .ctl_i   (s3_ctl_q),
    .ready_o (sqrt_rdy),
    .root_o  (root),
    .ctl_o   (root_ctl),
    .ready_i (out_o.ready)
  );

  // The root is cut or zero-extended to the result field.
  assign out_o.valid        = root_ctl.valid;
  assign out_o.overlap      = root_ctl.overlap;
  assign out_o.gap_distance = DIST_W'(root);

endmodule
`default_nettype wire

>>> sv/rmd_checker.sv
// Port-level checks of the rectangle distance block and their bind.
`default_nettype none
`include "rectangle_min_distance_defines.svh"
module rmd_checker import rmd_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [DIST_W-1:0] gap_distance_i,
  input wire logic              overlap_i
);

  // A stalled result stays offered.
  `RMD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // Overlapping rectangles always report distance zero.
  `RMD_ASSERT_NOW(a_overlap_zero, clk_i, rst_ni, out_valid_i && overlap_i, gap_distance_i == '0)

  // With the output stage empty no stage can be stalled, so the input is ready.
  `RMD_ASSERT_NOW(a_empty_ready, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // A draining output lets the whole pipeline advance.
  `RMD_ASSERT_NOW(a_drain_ready, clk_i, rst_ni, out_ready_i, in_ready_i)

endmodule

bind rectangle_min_distance rmd_checker u_rmd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .gap_distance_i (out_o.gap_distance),
  .overlap_i      (out_o.overlap)
);
`default_nettype wire

>>> tb/rectangle_min_distance_test.sv
// Self-checking testbench for the rectangle minimum distance block.
module rectangle_min_distance_test import rmd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // The block runs at its default coordinate width (signed Q16.8).
  localparam int unsigned COORD_W = COORD_BITS_DEF;
  // Pipeline depth given by the block: one stage per root bit plus the front stages.
  localparam int unsigned PIPE_DEPTH = COORD_W + 4;
  // Number of cycles the receiver holds off during the back-pressure test.
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  // The run is declared hung after this many cycles with no word moving on either side.
  localparam int unsigned WATCHDOG_CYCLES = 4000;
  localparam int unsigned MAX_REPORTS = 10;

  localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN = -(1 << (COORD_W - 1));

  // One input word: two rectangles, each as lower-left and upper-right corners.
  typedef struct packed {
    logic signed [COORD_W-1:0] a_left;
    logic signed [COORD_W-1:0] a_bottom;
    logic signed [COORD_W-1:0] a_right;
    logic signed [COORD_W-1:0] a_top;
    logic signed [COORD_W-1:0] b_left;
    logic signed [COORD_W-1:0] b_bottom;
    logic signed [COORD_W-1:0] b_right;
    logic signed [COORD_W-1:0] b_top;
  } rect_pair_t;

  // One output word: the distance and the overlap flag.
  typedef struct packed {
    logic [DIST_W-1:0] gap_distance;
    logic              overlap;
  } dist_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rmd_in_if #(.COORD_BITS(COORD_W)) pair_if ();
  rmd_out_if                        dist_if ();

  rectangle_min_distance #(.COORD_BITS(COORD_W)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pair_if),
    .out_o (dist_if)
  );

  // Distances expected from the block, oldest first.
  dist_result_t expected_dist_q[$];

  int unsigned fail_count     = 0;
  int unsigned stalled_cycles = 0;

  // Idle rates in percent for the sending and the receiving side.
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;

  // The test side bumps hold_requests; the receiver notices the change and
  // starts a long hold that it counts down on its own.
  int unsigned hold_requests = 0;
  int unsigned holds_taken   = 0;
  int unsigned hold_left     = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Integer square root of dx^2 + dy^2, one result bit at a time from the top.
  // Both gaps are below 2^24, so the sum of squares fits easily in 64 bits.
  function automatic logic [DIST_W-1:0] floor_hypot(input longint unsigned dx,
                                                    input longint unsigned dy);
    longint unsigned sum_sq;
    longint unsigned root;
    longint unsigned trial;
    sum_sq = dx * dx + dy * dy;
    root   = 0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sum_sq) root = trial;
    end
    return root[DIST_W-1:0];
  endfunction

  // Expected result of one rectangle pair.
  function automatic dist_result_t predict_min_distance(input rect_pair_t p);
    longint          al, ab, ar, at, bl, bb, br, bt;
    longint unsigned dx, dy;
    dist_result_t    res;
    al  = longint'($signed(p.a_left));
    ab  = longint'($signed(p.a_bottom));
    ar  = longint'($signed(p.a_right));
    at  = longint'($signed(p.a_top));
    bl  = longint'($signed(p.b_left));
    bb  = longint'($signed(p.b_bottom));
    br  = longint'($signed(p.b_right));
    bt  = longint'($signed(p.b_top));
    dx  = 0;
    dy  = 0;
    res = '0;
    // Shared edges and corners count as overlap: the tests are strict.
    if (!((ar < bl) || (al > br) || (at < bb) || (ab > bt))) begin
      res.overlap = 1'b1;
      return res;
    end
    // Inverted rectangles are taken as they come; when both horizontal (or
    // both vertical) tests hold, the second one decides the gap.
    if (ar < bl) dx = bl - ar;
    if (al > br) dx = al - br;
    if (at < bb) dy = bb - at;
    if (ab > bt) dy = ab - bt;
    if (dx == 0) begin
      res.gap_distance = DIST_W'(dy);
    end else if (dy == 0) begin
      res.gap_distance = DIST_W'(dx);
    end else begin
      res.gap_distance = floor_hypot(dx, dy);
    end
    return res;
  endfunction

  function automatic rect_pair_t make_pair(input int al, input int ab, input int ar,
                                           input int at, input int bl, input int bb,
                                           input int br, input int bt);
    rect_pair_t p;
    p.a_left   = COORD_W'(al);
    p.a_bottom = COORD_W'(ab);
    p.a_right  = COORD_W'(ar);
    p.a_top    = COORD_W'(at);
    p.b_left   = COORD_W'(bl);
    p.b_bottom = COORD_W'(bb);
    p.b_right  = COORD_W'(br);
    p.b_top    = COORD_W'(bt);
    return p;
  endfunction

  // Random pairs of three sorts: raw noise over the full range, tight clusters
  // where touching, overlap and inverted corners are common, and well-formed
  // rectangles placed to the side of, above, below or across each other.
  function automatic rect_pair_t random_pair();
    int         sort;
    int         span, ax, ay, aw, ah, bw, bh, gx, gy, bx, by, cx, cy;
    rect_pair_t p;
    sort = $urandom_range(9, 0);
    if (sort < 2) begin
      p = make_pair($urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom);
    end else if (sort < 4) begin
      cx = $urandom;
      cy = $urandom;
      p = make_pair(cx + $urandom_range(256, 0) - 128, cy + $urandom_range(256, 0) - 128,
                    cx + $urandom_range(256, 0) - 128, cy + $urandom_range(256, 0) - 128,
                    cx + $urandom_range(256, 0) - 128, cy + $urandom_range(256, 0) - 128,
                    cx + $urandom_range(256, 0) - 128, cy + $urandom_range(256, 0) - 128);
    end else begin
      span = (sort < 8) ? 2048 : (1 << 21);
      ax = $urandom_range(1 << 22, 0) - (1 << 21);
      ay = $urandom_range(1 << 22, 0) - (1 << 21);
      aw = $urandom_range(span, 0);
      ah = $urandom_range(span, 0);
      bw = $urandom_range(span, 0);
      bh = $urandom_range(span, 0);
      // A gap of zero makes the rectangles touch.
      gx = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(span, 0);
      gy = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(span, 0);
      case ($urandom_range(2, 0))
        0:       bx = ax + aw + gx;
        1:       bx = ax - gx - bw;
        default: bx = ax - bw / 2;
      endcase
      case ($urandom_range(2, 0))
        0:       by = ay + ah + gy;
        1:       by = ay - gy - bh;
        default: by = ay - bh / 2;
      endcase
      p = make_pair(ax, ay, ax + aw, ay + ah, bx, by, bx + bw, by + bh);
    end
    return p;
  endfunction

  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
  endtask

  // Sends one word. It always returns right after the rising edge at which the
  // word was taken, with valid still high, so back-to-back words need no gap.
  task automatic send_pair(input rect_pair_t p);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      pair_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pair_if.valid    <= 1'b1;
    pair_if.a_left   <= p.a_left;
    pair_if.a_bottom <= p.a_bottom;
    pair_if.a_right  <= p.a_right;
    pair_if.a_top    <= p.a_top;
    pair_if.b_left   <= p.b_left;
    pair_if.b_bottom <= p.b_bottom;
    pair_if.b_right  <= p.b_right;
    pair_if.b_top    <= p.b_top;
    // Ready is looked at on the falling edge, where it is settled; if it is
    // high there, the word goes in at the next rising edge.
    do @(negedge clk_i); while (!pair_if.ready);
    expected_dist_q.push_back(predict_min_distance(p));
    @(posedge clk_i);
  endtask

  // Drops valid after a burst. The extra edge keeps the lowering and a later
  // raise of valid in different time steps.
  task automatic end_burst();
    pair_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    while (expected_dist_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random ready, or a long hold when the test asks for one.
  always @(posedge clk_i) begin
    if (holds_taken != hold_requests) begin
      holds_taken = hold_requests;
      hold_left   = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      dist_if.ready <= 1'b0;
    end else begin
      dist_if.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end
  end

  // Result checker and watchdog. Both sample on the falling edge, so every
  // signal seen here holds the value it will have at the next rising edge.
  always @(negedge clk_i) begin : result_check
    dist_result_t want;
    if (rst_ni) begin
      if (dist_if.valid && dist_if.ready) begin
        if (expected_dist_q.size() == 0) begin
          report_failure($sformatf("unexpected result: distance %0d overlap %0b",
                                   dist_if.gap_distance, dist_if.overlap));
        end else begin
          want = expected_dist_q.pop_front();
          if (dist_if.gap_distance !== want.gap_distance || dist_if.overlap !== want.overlap)
          begin
            report_failure($sformatf(
              "mismatch: expected distance %0d overlap %0b, got distance %0d overlap %0b",
              want.gap_distance, want.overlap, dist_if.gap_distance, dist_if.overlap));
          end
        end
      end
      if ((pair_if.valid && pair_if.ready) || (dist_if.valid && dist_if.ready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_CYCLES) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // Overlap, containment, shared edges and shared corners all give the flag.
  task automatic test_overlap_and_touch();
    send_pair(make_pair(0, 0, 512, 512, 256, 256, 768, 768));       // partial overlap
    send_pair(make_pair(-1024, -1024, 1024, 1024, -1, -1, 1, 1));   // containment
    send_pair(make_pair(0, 0, 256, 256, 256, 0, 512, 256));         // shared vertical edge
    send_pair(make_pair(0, 0, 256, 256, 0, 256, 256, 512));         // shared horizontal edge
    send_pair(make_pair(0, 0, 256, 256, 256, 256, 512, 512));       // shared corner
    send_pair(make_pair(5, 5, 5, 5, 5, 5, 5, 5));                   // two equal points
    end_burst();
  endtask

  // A gap along one axis only is returned as it is.
  task automatic test_axis_gaps();
    send_pair(make_pair(0, 0, 256, 256, 257, 0, 512, 256));         // one LSB to the right
    send_pair(make_pair(1000, 0, 2000, 256, -500, 100, 400, 200));  // b to the left
    send_pair(make_pair(0, 0, 256, 256, 100, 1000, 200, 2000));     // b above
    send_pair(make_pair(0, 3000, 256, 4000, -50, -700, 50, 2999));  // b below by one LSB
    end_burst();
  endtask

  // Diagonal gaps go through the square root.
  task automatic test_diagonal_gaps();
    send_pair(make_pair(0, 0, 256, 256, 1024, 1280, 2048, 2048));   // 3-4-5 triangle
    send_pair(make_pair(0, 0, 0, 0, 1, 1, 2, 2));                   // one LSB each way
    send_pair(make_pair(0, 0, 0, 0, 256, 256, 300, 300));           // 45 degrees
    send_pair(make_pair(5000, 7000, 6000, 8000, -100, -300, 10, 20));
    end_burst();
  endtask

  // Rectangles with swapped corners are not repaired.
  task automatic test_inverted_corners();
    send_pair(make_pair(100, 0, -100, 256, 0, 0, 50, 256));         // both x tests hold
    send_pair(make_pair(0, 100, 256, -100, 0, 0, 256, 50));         // both y tests hold
    send_pair(make_pair(300, 300, -300, -300, 0, 0, 50, 50));       // both, both axes
    send_pair(make_pair(0, 0, 256, 256, 600, 600, 400, 400));       // b inverted, apart
    end_burst();
  endtask

  // The ends of the coordinate range, including the largest possible gap.
  task automatic test_coordinate_extremes();
    send_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_pair(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_pair(make_pair(COORD_MIN, 0, COORD_MIN, 0, COORD_MAX, 0, COORD_MAX, 0));
    send_pair(make_pair(0, COORD_MAX, 0, COORD_MAX, 0, COORD_MIN, 0, COORD_MIN));
    send_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, -1, -1, -1, -1));
    send_pair(make_pair(-1, -1, -1, -1, 0, 0, 0, 0));
    end_burst();
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned src_pct,
                                     input int unsigned sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (count) send_pair(random_pair());
    end_burst();
  endtask

  // The receiver stops for a long stretch while words keep coming, so the
  // pipeline fills and the input has to stall.
  task automatic test_output_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_requests++;
    repeat (120) send_pair(random_pair());
    end_burst();
  endtask

  // The sender stops until the pipeline has emptied, then starts again.
  task automatic test_drain_pause();
    src_idle_pct  = 10;
    sink_idle_pct = 10;
    repeat (40) send_pair(random_pair());
    end_burst();
    wait_for_results();
    repeat (40) send_pair(random_pair());
    end_burst();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    pair_if.valid    <= 1'b0;
    pair_if.a_left   <= '0;
    pair_if.a_bottom <= '0;
    pair_if.a_right  <= '0;
    pair_if.a_top    <= '0;
    pair_if.b_left   <= '0;
    pair_if.b_bottom <= '0;
    pair_if.b_right  <= '0;
    pair_if.b_top    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words run with light idling on both sides.
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    test_overlap_and_touch();
    test_axis_gaps();
    test_diagonal_gaps();
    test_inverted_corners();
    test_coordinate_extremes();

    // Slow receiver, then slow sender, then both at full rate.
    test_random_traffic(300, 36, 85);
    test_random_traffic(300, 85, 36);
    test_random_traffic(300, 0, 0);
    test_output_backpressure();
    test_drain_pause();

    // Let the pipeline empty, then give it time to show any extra word.
    wait_for_results();
    repeat (PIPE_DEPTH + 12) @(posedge clk_i);
    if (fail_count == 0 && expected_dist_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> rectangle_min_distance.f
+incdir+sv
sv/rmd_pkg.sv
sv/rmd_in_if.sv
sv/rmd_out_if.sv
sv/rmd_sqrt.sv
sv/rectangle_min_distance.sv
sv/rmd_checker.sv
tb/rectangle_min_distance_test.sv
